>>> sv/tdfq_pkg.sv
// Shared types and constants for the tail-drop handle queue.
package tdfq_pkg;

    // Default geometry
    localparam int DEPTH_DEFAULT       = 256;
    localparam int HANDLE_BITS_DEFAULT = 16;

    // Fixed field widths
    localparam int OPCODE_BITS  = 2;
    localparam int CFG_BITS     = 9;
    localparam int CFG_IDX_BITS = 2;
    localparam int PKT_OUT_BITS = 16;
    localparam int QLEN_BITS    = 9;
    localparam int BUDGET_BITS  = 3;

    // Budget value after a drop
    localparam logic [BUDGET_BITS-1:0] BUDGET_FULL = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_CAP       = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WAKE_THRESHOLD = 2'd1;

    // Reset values of the configuration registers
    localparam logic [CFG_BITS-1:0] SIZE_CAP_RESET       = 9'd256;
    localparam logic [CFG_BITS-1:0] WAKE_THRESHOLD_RESET = 9'd0;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_PEEK    = 2'd2,
        OP_FLUSH   = 2'd3
    } op_t;

    // Per-transaction result flags handed from control to the top level
    typedef struct packed {
        logic item_valid;
        logic dropped;
        logic wake_senders;
    } status_t;

endpackage

>>> sv/tdfq_store.sv
// Handle storage: single write port, single read port with registered read data.
module tdfq_store #(
    parameter int DEPTH       = tdfq_pkg::DEPTH_DEFAULT,
    parameter int HANDLE_BITS = tdfq_pkg::HANDLE_BITS_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [HANDLE_BITS-1:0]     wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [HANDLE_BITS-1:0]     rd_data
);

    logic [HANDLE_BITS-1:0] mem [DEPTH];
    logic [HANDLE_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/tdfq_ctrl.sv
// Queue control: pointers, occupancy, tail drop and wake-notify state.
module tdfq_ctrl #(
    parameter int DEPTH = tdfq_pkg::DEPTH_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 accept,
    input  tdfq_pkg::op_t                        opcode,
    input  logic [tdfq_pkg::CFG_BITS-1:0]        size_cap,
    input  logic [tdfq_pkg::CFG_BITS-1:0]        wake_threshold,
    output logic                                 wr_en,
    output logic [$clog2(DEPTH)-1:0]             wr_addr,
    output logic                                 rd_en,
    output logic [$clog2(DEPTH)-1:0]             rd_addr,
    output tdfq_pkg::status_t                    status,
    output logic [$clog2(DEPTH+1)-1:0]           count
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > tdfq_pkg::CFG_BITS) ? CNT_W : tdfq_pkg::CFG_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
    localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(DEPTH);

    logic [IDX_W-1:0]                  head_reg, head_next;
    logic [IDX_W-1:0]                  tail_reg, tail_next;
    logic [CNT_W-1:0]                  count_reg, count_next;
    logic [tdfq_pkg::BUDGET_BITS-1:0]  budget_reg, budget_next;
    logic                              notifying_reg, notifying_next;
    tdfq_pkg::status_t                 status_reg, status_next;

    logic [CMP_W-1:0] max_ext;
    logic [CMP_W-1:0] limit;
    logic [CNT_W-1:0] count_dec;
    logic [IDX_W-1:0] head_inc;
    logic [IDX_W-1:0] tail_inc;
    logic             not_full;
    logic             not_empty;
    logic             notify_on;

    always_comb begin
        max_ext   = CMP_W'(size_cap);
        limit     = (max_ext > DEPTH_CMP) ? DEPTH_CMP : max_ext;
        not_full  = CMP_W'(count_reg) < limit;
        not_empty = count_reg != '0;
        count_dec = count_reg - CNT_W'(1);
        head_inc  = (head_reg == LAST_IDX) ? '0 : head_reg + IDX_W'(1);
        tail_inc  = (tail_reg == LAST_IDX) ? '0 : tail_reg + IDX_W'(1);
        // notify starts when the post-dequeue length hits the threshold with a full budget
        notify_on = notifying_reg ||
                    ((CMP_W'(count_dec) == CMP_W'(wake_threshold)) &&
                     (budget_reg == tdfq_pkg::BUDGET_FULL));
    end

    always_comb begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        budget_next    = budget_reg;
        notifying_next = notifying_reg;
        status_next    = '0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        unique case (opcode)
            tdfq_pkg::OP_ENQUEUE: begin
                if (not_full) begin
                    wr_en      = accept;
                    tail_next  = tail_inc;
                    count_next = count_reg + CNT_W'(1);
                end else begin
                    status_next.dropped = 1'b1;
                    budget_next         = tdfq_pkg::BUDGET_FULL;
                    notifying_next      = 1'b0;
                end
            end
            tdfq_pkg::OP_DEQUEUE: begin
                if (not_empty) begin
                    rd_en                  = accept;
                    status_next.item_valid = 1'b1;
                    head_next              = head_inc;
                    count_next             = count_dec;
                    notifying_next         = notify_on;
                    if (notify_on && budget_reg != '0) begin
                        status_next.wake_senders = 1'b1;
                        budget_next = budget_reg - tdfq_pkg::BUDGET_BITS'(1);
                    end
                end
            end
            tdfq_pkg::OP_PEEK: begin
                if (not_empty) begin
                    rd_en                  = accept;
                    status_next.item_valid = 1'b1;
                end
            end
            tdfq_pkg::OP_FLUSH: begin
                head_next  = '0;
                tail_next  = '0;
                count_next = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            budget_reg    <= '0;
            notifying_reg <= 1'b0;
            status_reg    <= '0;
        end else if (accept) begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            budget_reg    <= budget_next;
            notifying_reg <= notifying_next;
            status_reg    <= status_next;
        end
    end

    assign wr_addr = tail_reg;
    assign rd_addr = head_reg;
    assign status  = status_reg;
    assign count   = count_reg;

endmodule

>>> sv/tail_drop_fifo_with_wake_notify.sv
// Top level of the tail-drop packet handle queue with wake notification.
//
//  channel  direction  handshake              payload
//  s_       in         s_valid / s_ready      s_opcode, s_packet_handle
//  m_       out        m_valid / m_ready      m_item_valid, m_packet_out, m_dropped,
//                                             m_wake_senders, m_queue_length
//  cfg_     in         cfg_wr_en (no wait)    cfg_index, cfg_wr_data
//
// One transaction per clock while m_ready does not stall the output: an accepted
// operation updates the queue state and issues its memory access, if any, at the
// accept edge; its result sits in the output register from the next cycle on.
// The rate is set by the one-port-each-way handle memory: each operation needs
// at most one write or one read, so operations never collide.
// s_ready is high whenever the output register is empty or being drained, so a
// stalled m_ready stalls the input side only while a result is held.
// Reset (aresetn low, synchronous) empties the queue, clears the notify state
// and loads size cap = 256, wake_threshold = 0. Memory contents are not reset.
module tail_drop_fifo_with_wake_notify #(
    parameter int DEPTH       = tdfq_pkg::DEPTH_DEFAULT,
    parameter int HANDLE_BITS = tdfq_pkg::HANDLE_BITS_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // operation input
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [tdfq_pkg::OPCODE_BITS-1:0]     s_opcode,
    input  logic [HANDLE_BITS-1:0]               s_packet_handle,
    // result output
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_item_valid,
    output logic [tdfq_pkg::PKT_OUT_BITS-1:0]    m_packet_out,
    output logic                                 m_dropped,
    output logic                                 m_wake_senders,
    output logic [tdfq_pkg::QLEN_BITS-1:0]       m_queue_length,
    // configuration writes
    input  logic                                 cfg_wr_en,
    input  logic [tdfq_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [tdfq_pkg::CFG_BITS-1:0]        cfg_wr_data
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    // bits carried across where the internal and port widths differ
    localparam int PKT_CB = (HANDLE_BITS < tdfq_pkg::PKT_OUT_BITS) ?
                            HANDLE_BITS : tdfq_pkg::PKT_OUT_BITS;
    localparam int QL_CB  = (CNT_W < tdfq_pkg::QLEN_BITS) ? CNT_W : tdfq_pkg::QLEN_BITS;

    logic                              m_valid_reg;
    logic [tdfq_pkg::CFG_BITS-1:0]     size_cap_reg;
    logic [tdfq_pkg::CFG_BITS-1:0]     wake_threshold_reg;

    logic                              accept;
    logic                              wr_en;
    logic [IDX_W-1:0]                  wr_addr;
    logic                              rd_en;
    logic [IDX_W-1:0]                  rd_addr;
    logic [HANDLE_BITS-1:0]            rd_data;
    tdfq_pkg::status_t                 status;
    logic [CNT_W-1:0]                  count;
    logic [tdfq_pkg::PKT_OUT_BITS-1:0] pkt_conv;
    logic [tdfq_pkg::QLEN_BITS-1:0]    qlen_conv;

    // output register free, or emptied this cycle
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // config registers; indexes past the list are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_cap_reg       <= tdfq_pkg::SIZE_CAP_RESET;
            wake_threshold_reg <= tdfq_pkg::WAKE_THRESHOLD_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == tdfq_pkg::REG_SIZE_CAP) begin
                size_cap_reg <= cfg_wr_data;
            end
            if (cfg_index == tdfq_pkg::REG_WAKE_THRESHOLD) begin
                wake_threshold_reg <= cfg_wr_data;
            end
        end
    end

    tdfq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .opcode         (tdfq_pkg::op_t'(s_opcode)),
        .size_cap       (size_cap_reg),
        .wake_threshold (wake_threshold_reg),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .status         (status),
        .count          (count)
    );

    tdfq_store #(
        .DEPTH       (DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_packet_handle),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        pkt_conv              = '0;
        pkt_conv[PKT_CB-1:0]  = rd_data[PKT_CB-1:0];
        qlen_conv             = '0;
        qlen_conv[QL_CB-1:0]  = count[QL_CB-1:0];
    end

    assign m_valid        = m_valid_reg;
    assign m_item_valid   = status.item_valid;
    // read data is stale unless this transaction returned a handle
    assign m_packet_out   = status.item_valid ? pkt_conv : '0;
    assign m_dropped      = status.dropped;
    assign m_wake_senders = status.wake_senders;
    assign m_queue_length = qlen_conv;

endmodule

>>> sv/tdfq_checker.sv
// Port-level checker for the tail-drop handle queue, bound to the top level.
module tdfq_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic                                 m_item_valid,
    input logic [tdfq_pkg::PKT_OUT_BITS-1:0]    m_packet_out,
    input logic                                 m_dropped,
    input logic                                 m_wake_senders
);

    // a held result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_packet_out) && $stable(m_item_valid))
        else $error("result changed while stalled");

    a_drop_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_dropped |-> !m_item_valid && !m_wake_senders)
        else $error("drop flagged together with a returned handle");

    a_wake_deq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_wake_senders |-> m_item_valid)
        else $error("wake without a dequeued handle");

    a_zero_pkt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item_valid |-> m_packet_out == '0)
        else $error("nonzero handle on an empty result");

endmodule

bind tail_drop_fifo_with_wake_notify tdfq_checker u_tdfq_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_item_valid   (m_item_valid),
    .m_packet_out   (m_packet_out),
    .m_dropped      (m_dropped),
    .m_wake_senders (m_wake_senders)
);
